@@ rtl/core/keyword_token_lexer_defines.svh @@
// Assertion macros shared by the keyword token lexer checkers.
`ifndef KEYWORD_TOKEN_LEXER_DEFINES_SVH
`define KEYWORD_TOKEN_LEXER_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define KTL_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// Check that must hold in the cycle after a stalled output transfer.
`define KTL_STALL_HOLD(name, expr) \
	`KTL_ASSERT(name, m_tvalid && !m_tready |=> expr)

`endif

@@ rtl/core/ktl_pkg.sv @@
// Types, constants and lookup functions of the keyword token lexer.
`default_nettype none

package ktl_pkg;

	localparam int PosBits  = 16;
	localparam int KwChars  = 6;
	localparam int KwBits   = KwChars * 8;
	localparam int LenBits  = 16;
	localparam int NumKw    = 7;
	localparam int QDepth   = 4;
	localparam int QPtrBits = $clog2(QDepth);
	localparam int QCntBits = $clog2(QDepth + 1);
	localparam int OutBits  = 40;

	typedef logic [4:0] kind_t;

	localparam kind_t KindComma   = 5'd0;
	localparam kind_t KindLBrace  = 5'd1;
	localparam kind_t KindRBrace  = 5'd2;
	localparam kind_t KindAssign  = 5'd3;
	localparam kind_t KindSemi    = 5'd4;
	localparam kind_t KindLParen  = 5'd5;
	localparam kind_t KindRParen  = 5'd6;
	localparam kind_t KindPlus    = 5'd7;
	localparam kind_t KindMinus   = 5'd8;
	localparam kind_t KindStar    = 5'd9;
	localparam kind_t KindSlash   = 5'd10;
	localparam kind_t KindLess    = 5'd11;
	localparam kind_t KindGreater = 5'd12;
	localparam kind_t KindNumber  = 5'd13;
	localparam kind_t KindIdent   = 5'd14;
	localparam kind_t KindFun     = 5'd15;
	localparam kind_t KindEnd     = 5'd22;
	localparam kind_t KindError   = 5'd23;

	// Keywords packed first letter in the lowest byte, zero above.
	localparam logic [KwBits-1:0] KwText [NumKw] = '{
		KwBits'(48'h0000_006E_7566),
		KwBits'(48'h656B_6F76_6E69),
		KwBits'(48'h6E72_7574_6572),
		KwBits'(48'h0000_0000_6669),
		KwBits'(48'h0000_0074_656C),
		KwBits'(48'h6574_6164_7075),
		KwBits'(48'h0000_0000_6F74)
	};
	localparam int KwLen [NumKw] = '{3, 6, 6, 2, 3, 6, 2};

	typedef enum logic [3:0] {
		ModeIdle   = 4'b0001,
		ModeNumber = 4'b0010,
		ModeWord   = 4'b0100,
		ModeError  = 4'b1000
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        start;
		logic [15:0]        length;
		logic [7:0]         bad;
		logic               last;
	} token_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     a;
		token_t     b;
	} push_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} punct_t;

	function automatic punct_t punct_lookup(input logic [7:0] c);
		punct_t r;
		r.hit  = 1'b1;
		r.kind = KindComma;
		unique case (c)
			8'h2C:   r.kind = KindComma;
			8'h7B:   r.kind = KindLBrace;
			8'h7D:   r.kind = KindRBrace;
			8'h3D:   r.kind = KindAssign;
			8'h3B:   r.kind = KindSemi;
			8'h28:   r.kind = KindLParen;
			8'h29:   r.kind = KindRParen;
			8'h2B:   r.kind = KindPlus;
			8'h2D:   r.kind = KindMinus;
			8'h2A:   r.kind = KindStar;
			8'h2F:   r.kind = KindSlash;
			8'h3C:   r.kind = KindLess;
			8'h3E:   r.kind = KindGreater;
			default: r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	function automatic kind_t word_kind(input logic [KwBits-1:0] buf_w,
			input logic [LenBits-1:0] len);
		kind_t r;
		r = KindIdent;
		if (len <= LenBits'(KwChars)) begin
			for (int i = 0; i < NumKw; i++) begin
				if (len == LenBits'(KwLen[i]) && buf_w == KwText[i]) begin
					r = KindFun + kind_t'(i);
				end
			end
		end
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/ktl_scan.sv @@
// Input register and scanning state: turns one byte into up to two tokens.
`default_nettype none

module ktl_scan import ktl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       in_end,
	input  wire logic       room,
	output push_t           push
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                end_s1;

	mode_t               mode_q, mode_d;
	logic [PosBits-1:0]  pos_q, pos_d;
	logic [PosBits-1:0]  start_q, start_d;
	logic [LenBits-1:0]  len_q, len_d;
	logic [KwBits-1:0]   kbuf_q, kbuf_d;

	logic                advance;
	token_t              ft, st;
	logic                flush, fv, sv;
	kind_t               wk;
	punct_t              pl;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
			end_s1  <= in_end;
		end
	end

	always_comb begin
		wk = word_kind(kbuf_q, len_q);
		pl = punct_lookup(char_s1);
		fv = mode_q == ModeNumber || mode_q == ModeWord;

		ft = '0;
		if (mode_q == ModeNumber || wk == KindIdent) begin
			ft.kind   = (mode_q == ModeNumber) ? KindNumber : KindIdent;
			ft.start  = 16'(start_q);
			ft.length = 16'(len_q);
		end else begin
			ft.kind   = wk;
		end

		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		len_d   = len_q;
		kbuf_d  = kbuf_q;
		flush   = 1'b0;
		sv      = 1'b0;
		st      = '0;

		if (end_s1) begin
			flush   = fv;
			sv      = 1'b1;
			st.kind = KindEnd;
			mode_d  = ModeIdle;
			pos_d   = '0;
			start_d = '0;
			len_d   = '0;
			kbuf_d  = '0;
		end else begin
			if (pos_q != '1) begin
				pos_d = pos_q + 1'b1;
			end
			if (mode_q != ModeError) begin
				if ((mode_q == ModeNumber && is_digit(char_s1)) ||
						(mode_q == ModeWord && is_letter(char_s1))) begin
					for (int i = 0; i < KwChars; i++) begin
						if (mode_q == ModeWord && len_q == LenBits'(i)) begin
							kbuf_d[i*8 +: 8] = char_s1;
						end
					end
					if (len_q != '1) begin
						len_d = len_q + 1'b1;
					end
				end else begin
					flush  = fv;
					mode_d = ModeIdle;
					if (is_space(char_s1)) begin
						mode_d = ModeIdle;
					end else if (is_digit(char_s1)) begin
						mode_d  = ModeNumber;
						start_d = pos_q;
						len_d   = LenBits'(1);
						kbuf_d  = '0;
					end else if (is_letter(char_s1)) begin
						mode_d  = ModeWord;
						start_d = pos_q;
						len_d   = LenBits'(1);
						kbuf_d  = KwBits'(char_s1);
					end else if (pl.hit) begin
						sv      = 1'b1;
						st.kind = pl.kind;
					end else begin
						sv      = 1'b1;
						st.kind = KindError;
						st.bad  = char_s1;
						mode_d  = ModeError;
					end
				end
			end
		end

		push = '0;
		if (advance) begin
			if (flush && sv) begin
				push.n      = 2'd2;
				push.a      = ft;
				push.b      = st;
				push.b.last = 1'b1;
			end else if (flush) begin
				push.n      = 2'd1;
				push.a      = ft;
				push.a.last = 1'b1;
			end else if (sv) begin
				push.n      = 2'd1;
				push.a      = st;
				push.a.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ModeIdle;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			kbuf_q  <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			kbuf_q  <= kbuf_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ktl_tokq.sv @@
// Token queue: takes up to two tokens a cycle, gives one a cycle while the reader is ready.
`default_nettype none

module ktl_tokq import ktl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output token_t     out_tok
);

	token_t                ent_q [QDepth];
	logic [QPtrBits-1:0]   wr_q, rd_q;
	logic [QCntBits-1:0]   cnt_q;
	logic                  pop;

	assign room      = cnt_q <= QCntBits'(QDepth - 2);
	assign out_valid = cnt_q != '0;
	assign out_tok   = ent_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_q + 1'b1] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPtrBits'(push.n);
			rd_q  <= rd_q + QPtrBits'(pop);
			cnt_q <= cnt_q + QCntBits'(push.n) - QCntBits'(pop);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/keyword_token_lexer.sv @@
// Keyword token lexer top level: byte stream in, token stream out.
//
// Slave channel: one source byte per transfer in s_tdata; s_tlast high marks
// the end of the text (s_tdata is then ignored). Master channel: one token per
// transfer, its kind in m_tuser and its span and bad byte in m_tdata; m_tlast
// flags the final token caused by an input item.
// Each byte gives zero, one or two tokens; the end marker gives one or two.
// A byte is taken every clock while the token queue has room for two tokens.
// The first token of a byte is offered once the byte has passed the input
// register and its token has been written into the four-entry queue; a
// second token follows once the first has been taken.
// Sustained rate is one byte per cycle while tokens average at most one per
// byte; the single-read queue output sets the token rate at one per cycle.
// When the receiver stalls the queue fills; once fewer than two entries are
// free the byte in the input register waits and s_tready drops. Reset empties
// the queue, clears the input register and returns the scanner to idle at
// offset zero; after an end marker the scanner returns to the same state.
`default_nettype none

module keyword_token_lexer import ktl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,  // [7:0] character
	input  wire logic               s_tlast,  // end_of_input
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// [15:0] text_start, [31:16] text_length, [39:32] bad_character
	output logic [OutBits-1:0]      m_tdata,
	output kind_t                   m_tuser,  // [4:0] token_kind
	output logic                    m_tlast   // last_of_run
);

	push_t  push;
	logic   room;
	token_t tok;

	ktl_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_end   (s_tlast),
		.room     (room),
		.push     (push)
	);

	ktl_tokq u_tokq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (tok)
	);

	assign m_tdata = OutBits'({tok.bad, tok.length, tok.start});
	assign m_tuser = tok.kind;
	assign m_tlast = tok.last;

endmodule

`default_nettype wire

@@ rtl/core/ktl_checker.sv @@
// Port checks of the keyword token lexer and their binding to the top level.
`default_nettype none
`include "keyword_token_lexer_defines.svh"

module ktl_checker import ktl_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [OutBits-1:0] m_tdata,
	input wire kind_t              m_tuser,
	input wire logic               m_tlast
);

	logic run_tok;

	assign run_tok = m_tuser == KindNumber || m_tuser == KindIdent;

	`KTL_STALL_HOLD(a_valid_hold, m_tvalid)
	`KTL_STALL_HOLD(a_data_hold, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`KTL_ASSERT(a_end_last, m_tvalid && m_tuser == KindEnd |-> m_tlast)
	`KTL_ASSERT(a_no_span, m_tvalid && !run_tok |-> m_tdata[31:0] == '0)
	`KTL_ASSERT(a_empty_ready, !m_tvalid |-> s_tready)

endmodule

bind keyword_token_lexer ktl_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
